// ===== hw/rtl/hpt3_pkg.sv =====
package hpt3_pkg;

    localparam int DATA_W = 32;
    localparam int TAG_W  = 2;

    localparam logic [TAG_W-1:0] TAG_BELOW = 2'd0;
    localparam logic [TAG_W-1:0] TAG_EQUAL = 2'd1;
    localparam logic [TAG_W-1:0] TAG_ABOVE = 2'd2;

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_PIV_RD  = 7'b0000010,
        S_PIV_CAP = 7'b0000100,
        S_LSCAN   = 7'b0001000,
        S_RSCAN   = 7'b0010000,
        S_SWAP    = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

endpackage

// ===== hw/rtl/hpt3_ram.sv =====
module hpt3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hpt3_cmp.sv =====
module hpt3_cmp
    import hpt3_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_lt
);

    // signed a < b, shared by both cursor scans (operands swapped for the right scan)
    assign o_lt = (i_a < i_b);

endmodule

// ===== hw/rtl/hoare_partition_three_groups_core.sv =====
// Three-group partition core. Signed 32-bit words are loaded one per cycle
// until a word flagged last arrives; words beyond MAX_ELEMS are dropped and the
// run is flagged overflow. The middle word (index n/2) becomes the pivot and the
// store is partitioned in place with two cursors, then every word is emitted in
// its new order tagged below (0), equal (1) or above (2), with the pivot. The
// store is one RAM with one write and one registered read port, and a single
// signed comparator serves both cursor scans. The partition starts with the
// pivot read (S_PIV_RD, then S_PIV_CAP); each cursor pass then runs the scan
// steps, a stop for each cursor (the right one also writes the left slot
// unless the cursors crossed) and the second swap write. The emit phase
// streams one word per cycle when the output is not stalled, after a
// registered RAM read and the output register. Input ready is high only
// while loading.
module hoare_partition_three_groups_core
    import hpt3_pkg::*;
#(
    parameter int MAX_ELEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_elem_value,
    input  logic                     i_last_element,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [TAG_W-1:0]         o_group_tag,
    output logic signed [DATA_W-1:0] o_pivot_value,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    localparam int AW   = $clog2(MAX_ELEMS);
    localparam int CNTW = $clog2(MAX_ELEMS + 1);
    localparam int CW   = CNTW + 1;

    t_state r_state, n_state;

    logic [CNTW-1:0]          r_count, n_count;
    logic [CNTW-1:0]          r_n, n_n;
    logic signed [CW-1:0]     r_pl, n_pl;
    logic signed [CW-1:0]     r_pr, n_pr;
    logic signed [DATA_W-1:0] r_pivot, n_pivot;
    logic signed [DATA_W-1:0] r_lval, n_lval;
    logic                     r_ovf, n_ovf;
    logic [CNTW-1:0]          r_idx, n_idx;
    logic [CNTW-1:0]          r_rd_idx, n_rd_idx;
    logic                     r_rd_v, n_rd_v;
    logic                     r_ovalid, n_ovalid;
    logic signed [DATA_W-1:0] r_oval;
    logic [TAG_W-1:0]         r_otag;
    logic                     r_olast;

    logic                     w_we, w_re;
    logic [AW-1:0]            w_waddr, w_raddr;
    logic signed [DATA_W-1:0] w_wdata, w_rdata;
    logic signed [DATA_W-1:0] w_cmp_a, w_cmp_b;
    logic                     w_lt;

    logic                     w_in_acc, w_store, w_load, w_issue, w_out_acc;
    logic signed [CW-1:0]     w_n_s, w_last_s, w_pl_inc, w_pr_dec, w_idx_s;
    logic [CNTW-1:0]          w_half, w_cnt_inc;
    logic [TAG_W-1:0]         w_tag;

    hpt3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hpt3_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_lt (w_lt)
    );

    assign o_ready   = (r_state == S_LOAD);
    assign w_in_acc  = i_valid && o_ready;
    assign w_store   = (r_count < CNTW'(MAX_ELEMS));
    assign w_cnt_inc = r_count + CNTW'(1);

    assign w_n_s    = $signed({1'b0, r_n});
    assign w_last_s = w_n_s - $signed(CW'(1));
    assign w_pl_inc = r_pl + $signed(CW'(1));
    assign w_pr_dec = r_pr - $signed(CW'(1));
    assign w_half   = r_n >> 1;

    // left scan: word < pivot; right scan: pivot < word
    assign w_cmp_a = (r_state == S_RSCAN) ? r_pivot : w_rdata;
    assign w_cmp_b = (r_state == S_RSCAN) ? w_rdata : r_pivot;

    assign w_out_acc = r_ovalid && i_ready;
    assign w_load    = (r_state == S_EMIT) && r_rd_v && (!r_ovalid || i_ready);
    assign w_issue   = (r_state == S_EMIT) && (r_idx < r_n) && (!r_rd_v || w_load);
    assign w_idx_s   = $signed({1'b0, r_rd_idx});

    always_comb begin
        if (w_idx_s <= r_pr) begin
            w_tag = TAG_BELOW;
        end else if (w_idx_s < r_pl) begin
            w_tag = TAG_EQUAL;
        end else begin
            w_tag = TAG_ABOVE;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_pl     = r_pl;
        n_pr     = r_pr;
        n_pivot  = r_pivot;
        n_lval   = r_lval;
        n_ovf    = r_ovf;
        n_idx    = r_idx;
        n_rd_idx = r_rd_idx;
        n_rd_v   = r_rd_v;
        n_ovalid = r_ovalid;
        w_we     = 1'b0;
        w_waddr  = r_count[AW-1:0];
        w_wdata  = i_elem_value;
        w_re     = 1'b0;
        w_raddr  = r_pl[AW-1:0];

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_store) begin
                        w_we    = 1'b1;
                        n_count = w_cnt_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_element) begin
                        n_n     = w_store ? w_cnt_inc : r_count;
                        n_pl    = '0;
                        n_pr    = $signed({1'b0, n_n}) - $signed(CW'(1));
                        n_state = S_PIV_RD;
                    end
                end
            end
            S_PIV_RD: begin
                w_re    = 1'b1;
                w_raddr = w_half[AW-1:0];
                n_state = S_PIV_CAP;
            end
            S_PIV_CAP: begin
                n_pivot = w_rdata;
                w_re    = 1'b1;
                w_raddr = r_pl[AW-1:0];
                n_state = S_LSCAN;
            end
            S_LSCAN: begin
                w_re = 1'b1;
                if ((r_pl < w_last_s) && w_lt) begin
                    n_pl    = w_pl_inc;
                    w_raddr = w_pl_inc[AW-1:0];
                end else begin
                    n_lval  = w_rdata;
                    w_raddr = r_pr[AW-1:0];
                    n_state = S_RSCAN;
                end
            end
            S_RSCAN: begin
                if ((r_pr > $signed(CW'(0))) && w_lt) begin
                    n_pr    = w_pr_dec;
                    w_re    = 1'b1;
                    w_raddr = w_pr_dec[AW-1:0];
                end else if (r_pl <= r_pr) begin
                    // first half of the swap: left slot takes the right word
                    w_we    = 1'b1;
                    w_waddr = r_pl[AW-1:0];
                    w_wdata = w_rdata;
                    n_state = S_SWAP;
                end else begin
                    n_idx   = '0;
                    n_rd_v  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_pr[AW-1:0];
                w_wdata = r_lval;
                n_pl    = w_pl_inc;
                n_pr    = w_pr_dec;
                // next read never hits the right slot written this cycle
                if (w_pl_inc <= w_pr_dec) begin
                    w_re    = 1'b1;
                    w_raddr = w_pl_inc[AW-1:0];
                    n_state = S_LSCAN;
                end else begin
                    n_idx   = '0;
                    n_rd_v  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_re    = w_issue;
                w_raddr = r_idx[AW-1:0];
                if (w_issue) begin
                    n_rd_idx = r_idx;
                    n_idx    = r_idx + CNTW'(1);
                end
                n_rd_v   = w_issue || (r_rd_v && !w_load);
                n_ovalid = w_load || (r_ovalid && !i_ready);
                if (w_out_acc && r_olast) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_n      <= '0;
            r_pl     <= '0;
            r_pr     <= '0;
            r_pivot  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_rd_v   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_pl     <= n_pl;
            r_pr     <= n_pr;
            r_pivot  <= n_pivot;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_rd_v   <= n_rd_v;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lval   <= n_lval;
        r_rd_idx <= n_rd_idx;
        if (w_load) begin
            r_oval  <= w_rdata;
            r_otag  <= w_tag;
            r_olast <= (r_rd_idx == (r_n - CNTW'(1)));
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_value   = r_oval;
    assign o_group_tag   = r_otag;
    assign o_pivot_value = r_pivot;
    assign o_last_out    = r_olast;
    assign o_overflow    = r_ovf;

    a_valid_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_EMIT))
        else $error("output word valid outside emit phase");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_element) |=> (r_state == S_PIV_RD))
        else $error("last word did not start the partition");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LSCAN) || (r_state == S_RSCAN)) |->
        ((r_pl >= $signed(CW'(0))) && (r_pl < w_n_s) && (r_pr >= $signed(CW'(0)))
         && (r_pr < w_n_s)))
        else $error("cursor outside stored words during scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_ELEMS))
        else $error("element count above capacity");

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIV_RD) |-> (r_n != '0))
        else $error("partition started on an empty run");

endmodule
